// ===== design/ddce_pkg.sv =====
// Shared constants, types and command codes of the dual potentiometer command engine.
// No dependencies; the channel interfaces and the top level import this package.
`default_nettype none

package ddce_pkg;

    localparam int CMD_W  = 4;
    localparam int ADDR_W = 4;
    localparam int DATA_W = 16;

    localparam int NUM_WIPERS_DEF = 2;
    localparam int WIPER_BITS_DEF = 10;
    localparam int MEM_WORDS_DEF  = 16;

    typedef logic [CMD_W-1:0]  t_cmd;
    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [DATA_W-1:0] t_data;

    localparam t_cmd CMD_NOP         = 4'd0;
    localparam t_cmd CMD_RESTORE     = 4'd1;
    localparam t_cmd CMD_STORE_WIPER = 4'd2;
    localparam t_cmd CMD_STORE_DATA  = 4'd3;
    localparam t_cmd CMD_SHR_ONE     = 4'd4;
    localparam t_cmd CMD_SHR_ALL     = 4'd5;
    localparam t_cmd CMD_DEC_ONE     = 4'd6;
    localparam t_cmd CMD_DEC_ALL     = 4'd7;
    localparam t_cmd CMD_REFRESH     = 4'd8;
    localparam t_cmd CMD_READ_MEM    = 4'd9;
    localparam t_cmd CMD_READ_WIPER  = 4'd10;
    localparam t_cmd CMD_WRITE_WIPER = 4'd11;
    localparam t_cmd CMD_SHL_ONE     = 4'd12;
    localparam t_cmd CMD_SHL_ALL     = 4'd13;
    localparam t_cmd CMD_INC_ONE     = 4'd14;
    localparam t_cmd CMD_INC_ALL     = 4'd15;

endpackage

`default_nettype wire

// ===== design/ddce_if.sv =====
// Valid/ready channel interfaces for frames in and readback words out.
// Depends on ddce_pkg for the payload types.
`default_nettype none

interface ddce_in_if;
    import ddce_pkg::*;

    logic  valid;
    logic  ready;
    logic  kind;
    t_cmd  command;
    t_addr address;
    t_data data;

    modport source (output valid, output kind, output command, output address,
                    output data, input ready);
    modport sink   (input valid, input kind, input command, input address,
                    input data, output ready);
endinterface

interface ddce_out_if;
    import ddce_pkg::*;

    logic  valid;
    logic  ready;
    t_data sdo_word;

    modport source (output valid, output sdo_word, input ready);
    modport sink   (input valid, input sdo_word, output ready);
endinterface

`default_nettype wire

// ===== design/ddce_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered, enabled read.
// No dependencies.
`default_nettype none

module ddce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== design/dual_digipot_command_engine.sv =====
// Top level of the dual digital potentiometer command engine.
// Depends on ddce_pkg, the channel interfaces in ddce_if.sv and the RAM in ddce_ram.sv.
//
//   Channel    Direction  Payload                               Accepted when
//   i_item     in         kind, command, address, data          valid && ready
//   o_result   out        sdo_word                              valid && ready
//
// Each item is handled at the edge that accepts it: the frame is decoded and
// the wipers and memory are updated at that edge, and the readback word as it
// stood before the item is loaded into the output register at that same edge.
// A new item is taken in every cycle in which the output register is empty or
// is being drained, so the output register is the only thing that can stall.
// Reset is synchronous and active low; it puts the wipers and the low memory
// words at midscale and marks every memory RAM entry as zero, with no sweep.
// While reset is held the engine takes no items.
`default_nettype none

module dual_digipot_command_engine #(
    parameter int NUM_WIPERS = ddce_pkg::NUM_WIPERS_DEF,
    parameter int WIPER_BITS = ddce_pkg::WIPER_BITS_DEF,
    parameter int MEM_WORDS  = ddce_pkg::MEM_WORDS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ddce_in_if.sink    i_item,
    ddce_out_if.source o_result
);
    import ddce_pkg::*;

    // Index widths for the wipers and the memory words.
    localparam int WW  = (NUM_WIPERS > 1) ? $clog2(NUM_WIPERS) : 1;
    localparam int AW  = $clog2(MEM_WORDS);
    // The memory words that the wipers restore from are mirrored in flip-flops,
    // so that restore and refresh need no RAM access.
    localparam int NSH = (NUM_WIPERS < MEM_WORDS) ? NUM_WIPERS : MEM_WORDS;

    localparam logic [WIPER_BITS-1:0] WIPER_MAX = '1;
    localparam logic [WIPER_BITS-1:0] WIPER_MID = {1'b1, {(WIPER_BITS-1){1'b0}}};

    // Saturating and clamped wiper arithmetic.
    function automatic logic [WIPER_BITS-1:0] shift_up(input logic [WIPER_BITS-1:0] v);
        return v[WIPER_BITS-1] ? WIPER_MAX : {v[WIPER_BITS-2:0], 1'b0};
    endfunction

    function automatic logic [WIPER_BITS-1:0] step_up(input logic [WIPER_BITS-1:0] v);
        return (v == WIPER_MAX) ? WIPER_MAX : v + 1'b1;
    endfunction

    function automatic logic [WIPER_BITS-1:0] step_down(input logic [WIPER_BITS-1:0] v);
        return (v == '0) ? '0 : v - 1'b1;
    endfunction

    // State.
    logic [NUM_WIPERS-1:0][WIPER_BITS-1:0] r_wiper, n_wiper;
    logic [NSH-1:0][DATA_W-1:0]            r_nv_low, n_nv_low;
    logic [MEM_WORDS-1:0]                  r_mem_vld;
    t_data                                 r_readback;
    logic                                  r_rb_pend;
    logic                                  r_rd_vld;
    t_cmd                                  r_last_cmd;
    t_addr                                 r_last_addr;
    t_data                                 r_last_data;
    logic                                  r_out_vld;
    t_data                                 r_sdo;

    // Frame decode.
    logic            in_ready;
    logic            accept;
    t_cmd            eff_cmd;
    t_addr           eff_addr;
    t_data           eff_data;
    logic [WW-1:0]   a_idx;
    logic [AW-1:0]   m_idx;
    logic [AW-1:0]   a_mem;
    logic [WIPER_BITS-1:0] wiper_a;
    logic            m_in_shadow;
    t_data           shadow_m;
    t_data           rb_now;
    t_data           ram_q;
    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    t_data           ram_wdata;
    logic            ram_re;

    assign in_ready       = i_rst_n && (!r_out_vld || o_result.ready);
    assign i_item.ready   = in_ready;
    assign accept         = i_item.valid && in_ready;
    assign o_result.valid = r_out_vld;
    assign o_result.sdo_word = r_sdo;

    // A select strobe replays the last full frame.
    assign eff_cmd  = i_item.kind ? r_last_cmd  : i_item.command;
    assign eff_addr = i_item.kind ? r_last_addr : i_item.address;
    assign eff_data = i_item.kind ? r_last_data : i_item.data;

    // The address wraps by the wiper count and by the memory size; both are
    // small constant tables over the sixteen address codes.
    always_comb begin
        a_idx = '0;
        m_idx = '0;
        for (int k = 0; k < (1 << ADDR_W); k++) begin
            if (eff_addr == ADDR_W'(k)) begin
                a_idx = WW'(k % NUM_WIPERS);
                m_idx = AW'(k % MEM_WORDS);
            end
        end
    end

    // The addressed wiper and the memory word that belongs to it.
    always_comb begin
        a_mem   = '0;
        wiper_a = r_wiper[0];
        for (int i = 0; i < NUM_WIPERS; i++) begin
            if (a_idx == WW'(i)) begin
                a_mem   = AW'(i % MEM_WORDS);
                wiper_a = r_wiper[i];
            end
        end
    end

    // Memory word selected by a read, when it lives in the mirrored low words.
    assign m_in_shadow = {1'b0, m_idx} < (AW+1)'(NSH);

    always_comb begin
        shadow_m = r_nv_low[0];
        for (int j = 0; j < NSH; j++) begin
            if (m_idx == AW'(j)) begin
                shadow_m = r_nv_low[j];
            end
        end
    end

    // Next wiper values.
    always_comb begin
        logic [WIPER_BITS-1:0] w;
        logic [WIPER_BITS-1:0] restore;
        logic                  sel;
        for (int i = 0; i < NUM_WIPERS; i++) begin
            w       = r_wiper[i];
            restore = r_nv_low[i % MEM_WORDS][WIPER_BITS-1:0];
            sel     = (a_idx == WW'(i));
            n_wiper[i] = w;
            unique case (eff_cmd)
                CMD_RESTORE:     if (sel) n_wiper[i] = restore;
                CMD_SHR_ONE:     if (sel) n_wiper[i] = w >> 1;
                CMD_SHR_ALL:     n_wiper[i] = w >> 1;
                CMD_DEC_ONE:     if (sel) n_wiper[i] = step_down(w);
                CMD_DEC_ALL:     n_wiper[i] = step_down(w);
                CMD_REFRESH:     n_wiper[i] = restore;
                CMD_WRITE_WIPER: if (sel) n_wiper[i] = eff_data[WIPER_BITS-1:0];
                CMD_SHL_ONE:     if (sel) n_wiper[i] = shift_up(w);
                CMD_SHL_ALL:     n_wiper[i] = shift_up(w);
                CMD_INC_ONE:     if (sel) n_wiper[i] = step_up(w);
                CMD_INC_ALL:     n_wiper[i] = step_up(w);
                CMD_NOP, CMD_STORE_WIPER, CMD_STORE_DATA,
                CMD_READ_MEM, CMD_READ_WIPER: n_wiper[i] = w;
            endcase
        end
    end

    // Next values of the mirrored low memory words.
    always_comb begin
        for (int j = 0; j < NSH; j++) begin
            n_nv_low[j] = r_nv_low[j];
            if (eff_cmd == CMD_STORE_DATA && m_idx == AW'(j)) begin
                n_nv_low[j] = eff_data;
            end
            if (eff_cmd == CMD_STORE_WIPER) begin
                for (int i = 0; i < NUM_WIPERS; i++) begin
                    if (a_idx == WW'(i) && (i % MEM_WORDS) == j) begin
                        n_nv_low[j] = DATA_W'(r_wiper[i]);
                    end
                end
            end
        end
    end

    // The full memory sits in RAM. Only reads of words above the mirrored
    // ones go to it; its registered output is picked up in the following cycle.
    assign ram_we    = accept && (eff_cmd == CMD_STORE_DATA || eff_cmd == CMD_STORE_WIPER);
    assign ram_waddr = (eff_cmd == CMD_STORE_DATA) ? m_idx : a_mem;
    assign ram_wdata = (eff_cmd == CMD_STORE_DATA) ? eff_data : DATA_W'(wiper_a);
    assign ram_re    = accept && eff_cmd == CMD_READ_MEM && !m_in_shadow;

    ddce_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MEM_WORDS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (m_idx),
        .o_rdata (ram_q)
    );

    // Readback word as it stands now; a RAM read still in flight supplies it,
    // and an entry never written reads as zero.
    assign rb_now = r_rb_pend ? (r_rd_vld ? ram_q : '0) : r_readback;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld   <= 1'b0;
            r_wiper     <= {NUM_WIPERS{WIPER_MID}};
            r_nv_low    <= {NSH{DATA_W'(WIPER_MID)}};
            r_mem_vld   <= '0;
            r_readback  <= '0;
            r_rb_pend   <= 1'b0;
            r_last_cmd  <= CMD_NOP;
            r_last_addr <= '0;
            r_last_data <= '0;
        end else begin
            if (accept) begin
                r_out_vld <= 1'b1;
            end else if (o_result.ready) begin
                r_out_vld <= 1'b0;
            end

            // Settle a finished RAM read into the readback register.
            if (r_rb_pend) begin
                r_readback <= rb_now;
                r_rb_pend  <= 1'b0;
            end

            if (accept) begin
                if (!i_item.kind) begin
                    r_last_cmd  <= i_item.command;
                    r_last_addr <= i_item.address;
                    r_last_data <= i_item.data;
                end
                r_wiper  <= n_wiper;
                r_nv_low <= n_nv_low;
                if (ram_we) begin
                    r_mem_vld[ram_waddr] <= 1'b1;
                end
                if (eff_cmd == CMD_READ_WIPER) begin
                    r_readback <= DATA_W'(wiper_a);
                end else if (eff_cmd == CMD_READ_MEM && m_in_shadow) begin
                    r_readback <= shadow_m;
                end
                if (ram_re) begin
                    r_rb_pend <= 1'b1;
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sdo <= rb_now;
        end
        if (ram_re) begin
            r_rd_vld <= r_mem_vld[m_idx];
        end
    end

    // An accepted item always leaves a result waiting in the next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_result.valid)
        else $error("accepted item produced no result");

    // A nop leaves the wipers and the mirrored memory words alone.
    a_nop_keeps_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && eff_cmd == CMD_NOP) |=> ($stable(r_wiper) && $stable(r_nv_low)))
        else $error("nop changed wiper or memory state");

    // A pending RAM readback only follows an accepted memory read.
    a_pend_from_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rb_pend |-> $past(accept && eff_cmd == CMD_READ_MEM))
        else $error("readback pending without a memory read");

    // A wiper read never leaves a RAM readback pending.
    a_wiper_read_direct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && eff_cmd == CMD_READ_WIPER) |=> !r_rb_pend)
        else $error("wiper read left a RAM readback pending");

endmodule

`default_nettype wire
